### rtl/core/wpf_pkg.sv
// Shared types and constants for the wildcard packet filter.
package wpf_pkg;

  localparam int MaxRules      = 1024;
  localparam int AddressDigits = 8;
  localparam int FieldDigits   = 8;
  localparam int IndexW        = 10;
  localparam int TallyW        = 16;
  localparam logic [3:0] WildcardNibble = 4'hF;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_APPEND   = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic        rule_is_permit;
    logic [31:0] rule_source_pattern;
    logic [31:0] rule_dest_pattern;
    logic [31:0] packet_source;
    logic [31:0] packet_dest;
  } in_data_t;

  typedef struct packed {
    logic              status;
    logic              permitted;
    logic              rule_matched;
    logic [IndexW-1:0] matched_rule_index;
    logic [TallyW-1:0] permitted_count;
  } out_data_t;

  typedef struct packed {
    logic        action;
    logic [31:0] src_pattern;
    logic [31:0] dst_pattern;
  } rule_t;

endpackage

### rtl/core/wildcard_packet_filter_unit.sv
// Wildcard packet filter: rule table with newest-first wildcard classification.
//
//  channel | ports                          | direction | request carries
//  --------+--------------------------------+-----------+-------------------------
//  in      | in_valid, in_stall, in_data    | to block  | clear / append / classify
//  out     | out_valid, out_stall, out_data | from block| status, verdict, count
//
// Sequence: clear, append and the unused code go from idle to the hand-off state; a
// classify first scans the stored rules newest first, stopping at the first hit or
// the oldest. Once out is free, hand-off loads the output register and frees the input.
// Reset: synchronous, active low; rule count and permit tally clear, the rule RAM keeps
// its contents (entries at or above the count are never used).
// Stalls: a finished result waits in a holding register for the output register, which
// then frees the input, so the next request is taken while out is stalled.
module wildcard_packet_filter_unit #(
  parameter int MAX_RULES      = wpf_pkg::MaxRules,
  parameter int ADDRESS_DIGITS = wpf_pkg::AddressDigits
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wpf_pkg::in_data_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wpf_pkg::out_data_t out_data
);

  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CW = $clog2(MAX_RULES + 1);
  // Digits past the 32-bit fields read as zero on both sides and always match.
  localparam int CmpDigits = (ADDRESS_DIGITS < wpf_pkg::FieldDigits) ?
                             ADDRESS_DIGITS : wpf_pkg::FieldDigits;
  localparam logic [CW-1:0] FullCount = CW'(MAX_RULES);
  localparam logic [wpf_pkg::TallyW-1:0] TallyMax = '1;

  // Per-nibble wildcard compare; the scan uses one copy for source and one for destination.
  function automatic logic pattern_match(input logic [31:0] pat, input logic [31:0] addr);
    logic ok;
    ok = 1'b1;
    for (int d = 0; d < wpf_pkg::FieldDigits; d++) begin
      if (d < CmpDigits && pat[4*d +: 4] != wpf_pkg::WildcardNibble &&
          pat[4*d +: 4] != addr[4*d +: 4]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  wpf_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]      rule_count_r, rule_count_nxt;
  logic [wpf_pkg::TallyW-1:0] tally_r, tally_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [31:0]        pkt_src_r, pkt_src_nxt;
  logic [31:0]        pkt_dst_r, pkt_dst_nxt;
  wpf_pkg::out_data_t res_r, res_nxt;
  wpf_pkg::out_data_t out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               in_take;
  logic               out_free;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  wpf_pkg::rule_t     ram_wdata;
  wpf_pkg::rule_t     ram_rdata;
  logic               hit;

  assign in_stall  = (state_r != wpf_pkg::ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Appends write at the current count; classify reads walk down from the top.
  assign ram_waddr = rule_count_r[AW-1:0];
  assign ram_wdata = '{action:      in_data.rule_is_permit,
                       src_pattern: in_data.rule_source_pattern,
                       dst_pattern: in_data.rule_dest_pattern};
  assign ram_raddr = (state_r == wpf_pkg::ST_SCAN) ? AW'(idx_r - 1'b1)
                                                   : AW'(rule_count_r - 1'b1);

  assign hit = pattern_match(ram_rdata.src_pattern, pkt_src_r) &&
               pattern_match(ram_rdata.dst_pattern, pkt_dst_r);

  wpf_ram #(
    .DATA_W ($bits(wpf_pkg::rule_t)),
    .DEPTH  (MAX_RULES)
  ) u_rule_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    rule_count_nxt = rule_count_r;
    tally_nxt      = tally_r;
    idx_nxt        = idx_r;
    pkt_src_nxt    = pkt_src_r;
    pkt_dst_nxt    = pkt_dst_r;
    res_nxt        = res_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    ram_we         = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      wpf_pkg::ST_IDLE: begin
        if (in_take) begin
          res_nxt                 = '0;
          res_nxt.permitted_count = tally_r;
          state_nxt               = wpf_pkg::ST_DONE;
          unique case (wpf_pkg::op_t'(in_data.operation))
            wpf_pkg::OP_CLEAR: begin
              rule_count_nxt          = '0;
              tally_nxt               = '0;
              res_nxt.permitted_count = '0;
            end
            wpf_pkg::OP_APPEND: begin
              if (rule_count_r == FullCount) begin
                res_nxt.status = 1'b1;
              end else begin
                ram_we         = 1'b1;
                rule_count_nxt = rule_count_r + 1'b1;
              end
            end
            wpf_pkg::OP_CLASSIFY: begin
              pkt_src_nxt = in_data.packet_source;
              pkt_dst_nxt = in_data.packet_dest;
              // RAM read of the newest rule is issued this cycle.
              if (rule_count_r != '0) begin
                idx_nxt   = AW'(rule_count_r - 1'b1);
                state_nxt = wpf_pkg::ST_SCAN;
              end
            end
            wpf_pkg::OP_NOP: begin
            end
          endcase
        end
      end
      wpf_pkg::ST_SCAN: begin
        // ram_rdata holds rule idx_r; the read of idx_r - 1 is already in flight.
        if (hit) begin
          res_nxt.rule_matched       = 1'b1;
          res_nxt.matched_rule_index = wpf_pkg::IndexW'(idx_r);
          res_nxt.permitted          = ram_rdata.action;
          if (ram_rdata.action && tally_r != TallyMax) begin
            tally_nxt               = tally_r + 1'b1;
            res_nxt.permitted_count = tally_r + 1'b1;
          end
          state_nxt = wpf_pkg::ST_DONE;
        end else if (idx_r == '0) begin
          state_nxt = wpf_pkg::ST_DONE;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      wpf_pkg::ST_DONE: begin
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = wpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wpf_pkg::ST_IDLE;
      rule_count_r <= '0;
      tally_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rule_count_r <= rule_count_nxt;
      tally_r      <= tally_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pkt_src_r  <= pkt_src_nxt;
    pkt_dst_r  <= pkt_dst_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Table never grows past its depth.
  assert property (@(posedge clk) disable iff (!rst_n) rule_count_r <= FullCount)
    else $error("rule count beyond table depth");

  // The scan only ever visits rules that were written since the last clear.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == wpf_pkg::ST_SCAN |-> CW'(idx_r) < rule_count_r)
    else $error("scan index outside written rules");

  // A result appears only out of the hand-off state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == wpf_pkg::ST_DONE))
    else $error("result raised outside hand-off");

  // An accepted request blocks the input on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) in_take |=> in_stall)
    else $error("second request taken while busy");

  // The tally only moves by one, or drops to zero on a clear.
  assert property (@(posedge clk) disable iff (!rst_n)
    tally_r != $past(tally_r) |-> tally_r == '0 || tally_r == $past(tally_r) + 1'b1)
    else $error("permit tally jumped");

endmodule

### rtl/core/wpf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module wpf_ram #(
  parameter int DATA_W = $bits(wpf_pkg::rule_t),
  parameter int DEPTH  = wpf_pkg::MaxRules,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### tb/wildcard_packet_filter_unit_tb.sv
// Self-checking testbench for the wildcard packet filter unit, with a newest-first ACL predictor.
module wildcard_packet_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Worst correct run is about 580 requests, each a full-table scan under the
  // longest gaps and stalls; the timeout allows several times that run.
  localparam int CycleLimit = 2_500_000;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  wpf_pkg::in_data_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  wpf_pkg::out_data_t out_data;

  wildcard_packet_filter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: private copy of the rule table and the permit tally.
  // ---------------------------------------------------------------------------
  wpf_pkg::rule_t acl_rules [wpf_pkg::MaxRules];
  int             acl_count = 0;
  logic [15:0]    acl_tally = '0;

  // Expected verdicts, oldest first, one per accepted request.
  wpf_pkg::out_data_t verdict_q [$];

  int  errors      = 0;
  int  sent        = 0;
  int  checked     = 0;
  int  cycle_count = 0;
  int  stall_left  = 0;
  bit  idle_on     = 1'b1;   // random gaps / back-pressure enabled
  bit  took;

  // Digits past the 32-bit field read as 0 on both sides, so only the
  // stored digits can miss.
  function automatic bit digits_match(input logic [31:0] pat, input logic [31:0] addr);
    int d;
    for (d = 0; d < wpf_pkg::AddressDigits && d < wpf_pkg::FieldDigits; d++)
      if (pat[4*d +: 4] != wpf_pkg::WildcardNibble && pat[4*d +: 4] != addr[4*d +: 4])
        return 1'b0;
    return 1'b1;
  endfunction

  // Applies one request to the predictor state and returns its verdict.
  function automatic wpf_pkg::out_data_t acl_predict(input wpf_pkg::in_data_t req);
    wpf_pkg::out_data_t v;
    int k;
    v = '0;
    case (wpf_pkg::op_t'(req.operation))
      wpf_pkg::OP_CLEAR: begin
        acl_count = 0;
        acl_tally = '0;
      end
      wpf_pkg::OP_APPEND: begin
        if (acl_count >= wpf_pkg::MaxRules) begin
          v.status = 1'b1;   // table full, rule dropped
        end else begin
          acl_rules[acl_count].action      = req.rule_is_permit;
          acl_rules[acl_count].src_pattern = req.rule_source_pattern;
          acl_rules[acl_count].dst_pattern = req.rule_dest_pattern;
          acl_count++;
        end
      end
      wpf_pkg::OP_CLASSIFY: begin
        // newest rule first; first hit decides
        for (k = acl_count - 1; k >= 0 && !v.rule_matched; k--) begin
          if (digits_match(acl_rules[k].src_pattern, req.packet_source) &&
              digits_match(acl_rules[k].dst_pattern, req.packet_dest)) begin
            v.rule_matched       = 1'b1;
            v.matched_rule_index = wpf_pkg::IndexW'(k);
            v.permitted          = acl_rules[k].action;
          end
        end
        if (v.permitted && acl_tally != '1)
          acl_tally++;
      end
      default: ;   // unused code: no state change
    endcase
    v.permitted_count = acl_tally;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic wpf_pkg::in_data_t compose(input wpf_pkg::op_t op, input logic permit,
                                       input logic [31:0] rs, input logic [31:0] rd,
                                       input logic [31:0] ps, input logic [31:0] pd);
    wpf_pkg::in_data_t r;
    r.operation           = op;
    r.rule_is_permit      = permit;
    r.rule_source_pattern = rs;
    r.rule_dest_pattern   = rd;
    r.packet_source       = ps;
    r.packet_dest         = pd;
    return r;
  endfunction

  // Mostly digits and wildcards, some 10..14 nibbles, now and then raw noise.
  function automatic logic [31:0] rand_pattern();
    logic [31:0] r;
    int d;
    int pick;
    if ($urandom_range(0, 7) == 0)
      return $urandom;
    for (d = 0; d < wpf_pkg::FieldDigits; d++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      r[4*d +: 4] = wpf_pkg::WildcardNibble;
      else if (pick < 85) r[4*d +: 4] = 4'($urandom_range(0, 9));
      else                r[4*d +: 4] = 4'($urandom_range(10, 14));
    end
    return r;
  endfunction

  // Address that hits the given pattern, sometimes with one digit knocked off.
  function automatic logic [31:0] packet_near(input logic [31:0] pat);
    logic [31:0] a;
    int d;
    for (d = 0; d < wpf_pkg::FieldDigits; d++) begin
      if (pat[4*d +: 4] == wpf_pkg::WildcardNibble)
        a[4*d +: 4] = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(10, 15))
                                                  : 4'($urandom_range(0, 9));
      else
        a[4*d +: 4] = pat[4*d +: 4];
    end
    if ($urandom_range(0, 5) == 0) begin
      d = $urandom_range(0, wpf_pkg::FieldDigits - 1);
      a[4*d +: 4] = ~a[4*d +: 4];
    end
    return a;
  endfunction

  // Drives one request and holds it until accepted; verdict is predicted at accept.
  // Valid stays high between back-to-back requests (no drop/raise in one step).
  task automatic push_request(input wpf_pkg::in_data_t req);
    int gap;
    wpf_pkg::out_data_t verdict;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    verdict   = acl_predict(req);
    verdict_q = {verdict_q, verdict};
    sent++;
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and output back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    took = rst_n && out_valid && !out_stall;
    if (took) begin
      checked++;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, out_data);
      end else begin
        wpf_pkg::out_data_t want;
        want = verdict_q.pop_front();
        cmp_field("status",             16'(want.status),             16'(out_data.status));
        cmp_field("permitted",          16'(want.permitted),          16'(out_data.permitted));
        cmp_field("rule_matched",       16'(want.rule_matched),       16'(out_data.rule_matched));
        cmp_field("matched_rule_index", 16'(want.matched_rule_index),
                  16'(out_data.matched_rule_index));
        cmp_field("permitted_count",    want.permitted_count,         out_data.permitted_count);
      end
    end
    // new stall draw after each taken result, and while nothing is offered,
    // so a result can land on any phase of a stall
    if (stall_left == 0 && (took || !out_valid))
      stall_left = idle_on ? $urandom_range(0, 3) : 0;
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d verdicts outstanding",
             $time, CycleLimit, verdict_q.size());
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty table denies everything; unused opcode only echoes the count.
  task automatic test_empty_and_unused();
    push_request(compose(wpf_pkg::OP_CLASSIFY, 1'b1, '1, '1, 32'h0000_0000, 32'hFFFF_FFFF));
    push_request(compose(wpf_pkg::OP_NOP, 1'b1, '1, '1, '1, '1));
    push_request(compose(wpf_pkg::OP_NOP, 1'b0, '0, '0, '0, '0));
  endtask

  // Newest matching rule wins over older ones; field extremes.
  task automatic test_newest_first();
    push_request(compose(wpf_pkg::OP_APPEND, 1'b0, 32'h1234_5678, 32'h8765_4321, '0, '0));
    push_request(compose(wpf_pkg::OP_APPEND, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1));
    push_request(compose(wpf_pkg::OP_APPEND, 1'b0, 32'h1234_FFFF, 32'hFFFF_4321, '0, '1));
    push_request(compose(wpf_pkg::OP_CLASSIFY, 1'b0, '0, '0, 32'h1234_5678, 32'h8765_4321));
    push_request(compose(wpf_pkg::OP_CLASSIFY, 1'b0, '0, '0, 32'h1234_9999, 32'h0000_4321));
    push_request(compose(wpf_pkg::OP_CLASSIFY, 1'b0, '0, '0, 32'h0000_0000, 32'hFFFF_FFFF));
    push_request(compose(wpf_pkg::OP_CLASSIFY, 1'b1, '1, '1, 32'hFFFF_FFFF, 32'h0000_0000));
    push_request(compose(wpf_pkg::OP_APPEND, 1'b1, 32'h0000_0000, 32'h0000_0000, '1, '1));
    push_request(compose(wpf_pkg::OP_CLASSIFY, 1'b0, '1, '1, 32'h0000_0000, 32'h0000_0000));
  endtask

  // Nibbles 10..15: literal compare, only 15 in a pattern is a wildcard.
  task automatic test_nondecimal_nibbles();
    push_request(compose(wpf_pkg::OP_APPEND, 1'b1, 32'hABCD_EABC, 32'hFFFF_FFFF, '0, '0));
    push_request(compose(wpf_pkg::OP_CLASSIFY, 1'b0, '0, '0, 32'hABCD_EABC, 32'hFEDC_BA98));
    push_request(compose(wpf_pkg::OP_CLASSIFY, 1'b0, '0, '0, 32'hABCD_EABB, 32'hFEDC_BA98));
    push_request(compose(wpf_pkg::OP_APPEND, 1'b0, 32'hFFFF_FFFF, 32'hEEEE_EEEE, '0, '0));
    push_request(compose(wpf_pkg::OP_CLASSIFY, 1'b0, '0, '0, 32'h1234_5678, 32'hEEEE_EEEE));
    push_request(compose(wpf_pkg::OP_CLASSIFY, 1'b0, '0, '0, 32'hFFFF_FFFF, 32'hEEEE_EEEF));
  endtask

  // Clear drops all rules and the tally; the table refills from index 0.
  task automatic test_clear();
    push_request(compose(wpf_pkg::OP_CLEAR, 1'b1, '1, '1, '1, '1));
    push_request(compose(wpf_pkg::OP_CLASSIFY, 1'b0, '0, '0, 32'h1234_5678, 32'h8765_4321));
    push_request(compose(wpf_pkg::OP_APPEND, 1'b1, 32'h0F0F_0F0F, 32'hF0F0_F0F0, '0, '0));
    push_request(compose(wpf_pkg::OP_CLASSIFY, 1'b0, '0, '0, 32'h0102_0304, 32'h5060_7080));
  endtask

  // Mixed traffic; packets mostly aimed at stored rules so the scan
  // ends at varied depths. Table kept small to bound scan time.
  task automatic test_random_mix(input int n_items);
    int i;
    int pick;
    int k;
    wpf_pkg::op_t op;
    logic [31:0] ps;
    logic [31:0] pd;
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 39) == 0)
        idle_on = ~idle_on;
      pick = $urandom_range(0, 99);
      if (acl_count >= 48 || pick < 3) op = wpf_pkg::OP_CLEAR;
      else if (pick < 38)              op = wpf_pkg::OP_APPEND;
      else if (pick < 93)              op = wpf_pkg::OP_CLASSIFY;
      else                             op = wpf_pkg::OP_NOP;
      ps = $urandom;
      pd = $urandom;
      if (op == wpf_pkg::OP_CLASSIFY && acl_count > 0 && $urandom_range(0, 3) != 0) begin
        k  = $urandom_range(0, acl_count - 1);
        ps = packet_near(acl_rules[k].src_pattern);
        pd = packet_near(acl_rules[k].dst_pattern);
      end
      push_request(compose(op, 1'($urandom_range(0, 1)), rand_pattern(), rand_pattern(),
                           ps, pd));
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_unused();
    test_newest_first();
    test_nondecimal_nibbles();
    test_clear();
    test_random_mix(558);

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    // drain: a stray result could still trail the last expected one
    repeat (wpf_pkg::MaxRules + 8) @(posedge clk);

    $display("covered %0d requests (clear, append, classify, unused code), %0d results checked",
             sent, checked);
    $display("newest-first priority, literal 10..15 nibbles, clears and mixed traffic");
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### wildcard_packet_filter_unit.f
rtl/core/wpf_pkg.sv
rtl/core/wpf_ram.sv
rtl/core/wildcard_packet_filter_unit.sv
tb/wildcard_packet_filter_unit_tb.sv
